// ===== src/assert_macros.svh =====
// assert_macros.svh: assertion macros used by the checker file tlvd_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLVD_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("tlvd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLVD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("tlvd assertion failed");

// Next-cycle implication that is checked through reset as well.
`define TLVD_ASSERT_NEXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("tlvd assertion failed");

`endif

// ===== src/tlvd_pkg.sv =====
// tlvd_pkg: types and constants of the TLV deframer.
// No dependencies; imported by the parser, the output buffer and the top level.
`default_nettype none

package tlvd_pkg;

  // Length byte that announces a 16-bit length
  localparam logic [7:0] ESCAPE_LEN = 8'hFF;

  // Parser phase
  typedef enum logic [2:0] {
    PH_TAG   = 3'd0,
    PH_LEN   = 3'd1,
    PH_LENHI = 3'd2,
    PH_LENLO = 3'd3,
    PH_VALUE = 3'd4
  } tlvd_phase_t;

  // One result item
  typedef struct packed {
    logic [15:0] msg_length;
    logic        msg_last;
    logic        has_value;
    logic [7:0]  value_byte;
    logic [7:0]  msg_tag;
  } tlvd_result_t;

endpackage

`default_nettype wire

// ===== src/tlvd_parser.sv =====
// tlvd_parser: phase machine that turns each accepted byte into zero or one result.
// Depends on tlvd_pkg.
`default_nettype none

module tlvd_parser
  import tlvd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         byte_accept,
  input  wire logic [7:0]   data_byte,
  output logic              res_valid,
  output tlvd_result_t      res
);

  tlvd_phase_t phase_r, phase_nxt;
  logic [7:0]  held_tag_r, held_tag_nxt;
  logic [7:0]  length_high_r, length_high_nxt;
  logic [15:0] total_length_r, total_length_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;

  logic [15:0] new_len;
  logic        len_known;
  logic        val_last;

  // Length as soon as it is complete in this byte
  always_comb begin
    new_len   = {8'd0, data_byte};
    len_known = 1'b0;
    unique case (phase_r)
      PH_LEN: begin
        new_len   = {8'd0, data_byte};
        len_known = (data_byte != ESCAPE_LEN);
      end
      PH_LENLO: begin
        new_len   = {length_high_r, data_byte};
        len_known = 1'b1;
      end
      default: begin
        new_len   = {8'd0, data_byte};
        len_known = 1'b0;
      end
    endcase
  end

  assign val_last = (bytes_left_r <= 16'd1);

  // Next state
  always_comb begin
    phase_nxt        = phase_r;
    held_tag_nxt     = held_tag_r;
    length_high_nxt  = length_high_r;
    total_length_nxt = total_length_r;
    bytes_left_nxt   = bytes_left_r;
    if (byte_accept) begin
      unique case (phase_r)
        PH_LEN, PH_LENLO: begin
          if (len_known) begin
            total_length_nxt = new_len;
            bytes_left_nxt   = new_len;
            phase_nxt        = (new_len == 16'd0) ? PH_TAG : PH_VALUE;
          end else begin
            phase_nxt = PH_LENHI;
          end
        end
        PH_LENHI: begin
          length_high_nxt = data_byte;
          phase_nxt       = PH_LENLO;
        end
        PH_VALUE: begin
          if (val_last) begin
            bytes_left_nxt = 16'd0;
            phase_nxt      = PH_TAG;
          end else begin
            bytes_left_nxt = bytes_left_r - 16'd1;
          end
        end
        // tag byte; unused codes behave the same
        default: begin
          held_tag_nxt = data_byte;
          phase_nxt    = PH_LEN;
        end
      endcase
    end
  end

  // Result outputs
  always_comb begin
    res_valid      = 1'b0;
    res.msg_tag    = held_tag_r;
    res.value_byte = 8'd0;
    res.has_value  = 1'b0;
    res.msg_last   = 1'b1;
    res.msg_length = 16'd0;
    unique case (phase_r)
      PH_LEN, PH_LENLO: begin
        // empty-message marker
        res_valid = byte_accept && len_known && (new_len == 16'd0);
      end
      PH_VALUE: begin
        res_valid      = byte_accept;
        res.value_byte = data_byte;
        res.has_value  = 1'b1;
        res.msg_last   = val_last;
        res.msg_length = total_length_r;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_TAG;
      held_tag_r     <= 8'd0;
      length_high_r  <= 8'd0;
      total_length_r <= 16'd0;
      bytes_left_r   <= 16'd0;
    end else begin
      phase_r        <= phase_nxt;
      held_tag_r     <= held_tag_nxt;
      length_high_r  <= length_high_nxt;
      total_length_r <= total_length_nxt;
      bytes_left_r   <= bytes_left_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/tlvd_out_buf.sv =====
// tlvd_out_buf: result register with a skid entry so the input side keeps moving.
// Depends on tlvd_pkg.
`default_nettype none

module tlvd_out_buf
  import tlvd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tlvd_result_t  push_res,
  output logic               can_accept,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tlvd_result_t       out_res
);

  logic         main_valid_r, main_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  tlvd_result_t main_r, main_nxt;
  tlvd_result_t skid_r, skid_nxt;
  logic         pop;

  assign pop        = main_valid_r && out_ready;
  assign can_accept = !skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_res    = main_r;

  // Fill and drain of the two entries
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_res;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

// ===== src/tlv_frame_deframer.sv =====
// tlv_frame_deframer: top level of the TLV deframer, parser plus output buffer.
// Depends on tlvd_pkg, tlvd_parser and tlvd_out_buf.
//
//   channel  direction  tdata                               tlast     tuser
//   in_      slave      [7:0] data_byte                     -         -
//   out_     master     [7:0] tag [15:8] value [31:16] len  msg_last  has_value
//
// One byte is accepted per clock while in_tready is high; the phase update and the result are
// formed in the same cycle, and the result is registered in the output register, or in the
// skid entry when that register is held. A two-entry output buffer (register plus skid) keeps
// in_tready high while a result waits; in_tready drops only when both entries are full.
// rst_n is synchronous, active low, and returns the parser to expecting a tag byte.
`default_nettype none

module tlv_frame_deframer
  import tlvd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] msg_tag, [15:8] value_byte, [31:16] msg_length
  output logic             out_tlast,  // msg_last
  output logic             out_tuser   // has_value
);

  logic         byte_accept;
  logic         res_valid;
  tlvd_result_t res;
  tlvd_result_t out_res;

  assign byte_accept = in_tvalid && in_tready;

  tlvd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (byte_accept),
    .data_byte   (in_tdata),
    .res_valid   (res_valid),
    .res         (res)
  );

  tlvd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_res   (res),
    .can_accept (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  // Pack the result transaction
  assign out_tdata = {out_res.msg_length, out_res.value_byte, out_res.msg_tag};
  assign out_tlast = out_res.msg_last;
  assign out_tuser = out_res.has_value;

endmodule

`default_nettype wire

// ===== src/tlvd_checker.sv =====
// tlvd_checker: port-level assertions for tlv_frame_deframer, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tlvd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        out_tuser
);

  logic        out_stall;
  logic        out_marker;
  logic [33:0] out_word;

  assign out_stall  = out_tvalid && !out_tready;
  assign out_marker = out_tvalid && !out_tuser;
  assign out_word   = {out_tdata, out_tlast, out_tuser};

  // A stalled result transaction holds its payload
  `TLVD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_word))

  // Reset empties the output
  `TLVD_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid)

  // Reset leaves the input side ready
  `TLVD_ASSERT_NEXT_ALWAYS(a_reset_ready, clk, !rst_n, in_tready)

  // Empty-message marker: last, no value, zero length
  `TLVD_ASSERT_SAME(a_empty_marker, clk, rst_n, out_marker, out_tlast && out_tdata[31:8] == '0)

  // A value byte always belongs to a message of nonzero length
  `TLVD_ASSERT_SAME(a_value_len, clk, rst_n, out_tvalid && out_tuser, out_tdata[31:16] != 16'd0)

endmodule

bind tlv_frame_deframer tlvd_checker u_tlvd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== bench/tb_tlv_frame_deframer.sv =====
// tb_tlv_frame_deframer: self-checking bench for the TLV deframer, directed then random streams.
// Depends on tlvd_pkg and tlv_frame_deframer; a class tracks message state and pending results.

// Tracks the message parser state and queues the results each accepted byte should produce
class tlv_result_board;
  tlvd_pkg::tlvd_phase_t  phase;
  logic [7:0]             cur_tag;
  logic [7:0]             len_hi;
  logic [15:0]            cur_len;
  logic [15:0]            left;
  tlvd_pkg::tlvd_result_t pending_results[$];
  int unsigned            n_errors;

  function new();
    phase    = tlvd_pkg::PH_TAG;
    cur_tag  = '0;
    len_hi   = '0;
    cur_len  = '0;
    left     = '0;
    n_errors = 0;
  endfunction

  // Length known: either an empty-message marker or start of the value bytes
  function void open_value(logic [15:0] len);
    tlvd_pkg::tlvd_result_t r;
    cur_len = len;
    left    = len;
    if (len == 16'd0) begin
      r.msg_tag    = cur_tag;
      r.value_byte = 8'h00;
      r.has_value  = 1'b0;
      r.msg_last   = 1'b1;
      r.msg_length = 16'd0;
      pending_results = {pending_results, r};
      phase = tlvd_pkg::PH_TAG;
    end else begin
      phase = tlvd_pkg::PH_VALUE;
    end
  endfunction

  // One accepted input transaction
  function void note_byte(logic [7:0] b);
    tlvd_pkg::tlvd_result_t r;
    case (phase)
      tlvd_pkg::PH_LEN: begin
        if (b == tlvd_pkg::ESCAPE_LEN) phase = tlvd_pkg::PH_LENHI;
        else open_value({8'h00, b});
      end
      tlvd_pkg::PH_LENHI: begin
        len_hi = b;
        phase  = tlvd_pkg::PH_LENLO;
      end
      tlvd_pkg::PH_LENLO: open_value({len_hi, b});
      tlvd_pkg::PH_VALUE: begin
        r.msg_tag    = cur_tag;
        r.value_byte = b;
        r.has_value  = 1'b1;
        r.msg_last   = (left <= 16'd1);
        r.msg_length = cur_len;
        pending_results = {pending_results, r};
        if (left <= 16'd1) begin
          left  = 16'd0;
          phase = tlvd_pkg::PH_TAG;
        end else begin
          left = left - 16'd1;
        end
      end
      default: begin
        cur_tag = b;
        phase   = tlvd_pkg::PH_LEN;
      end
    endcase
  endfunction

  // One accepted output transaction against the oldest pending result
  function void check_result(tlvd_pkg::tlvd_result_t got);
    tlvd_pkg::tlvd_result_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: tag %h value %h has_value %b last %b length %0d",
             got.msg_tag, got.value_byte, got.has_value, got.msg_last, got.msg_length);
      n_errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.msg_tag !== want.msg_tag) begin
      $error("msg_tag: expected %h, got %h", want.msg_tag, got.msg_tag);
      n_errors++;
    end
    if (got.value_byte !== want.value_byte) begin
      $error("value_byte: expected %h, got %h", want.value_byte, got.value_byte);
      n_errors++;
    end
    if (got.has_value !== want.has_value) begin
      $error("has_value: expected %b, got %b", want.has_value, got.has_value);
      n_errors++;
    end
    if (got.msg_last !== want.msg_last) begin
      $error("msg_last: expected %b, got %b", want.msg_last, got.msg_last);
      n_errors++;
    end
    if (got.msg_length !== want.msg_length) begin
      $error("msg_length: expected %0d, got %0d", want.msg_length, got.msg_length);
      n_errors++;
    end
  endfunction
endclass

module tb_tlv_frame_deframer;
  import tlvd_pkg::*;

  localparam int unsigned RANDOM_BYTES = 230;
  localparam int unsigned STALL_CYCLES = 80;
  localparam int unsigned WDOG_LIMIT   = 3000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  tlv_result_board board;
  bit              src_idle_on;
  bit              sink_idle_on;
  bit              stall_req;
  int unsigned     n_sent;

  tlv_frame_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Clock, period 4
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offer one byte, with random idle cycles ahead of it, until the transaction completes
  task automatic send_byte(input logic [7:0] b);
    while (src_idle_on && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_byte(b);
    n_sent++;
  endtask

  // Tag, length (short or escaped), then n_vals random value bytes
  task automatic send_msg(input logic [7:0] tag, input logic [15:0] len, input bit ext,
                          input int unsigned n_vals);
    send_byte(tag);
    if (ext || len >= 16'd255) begin
      send_byte(ESCAPE_LEN);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else begin
      send_byte(len[7:0]);
    end
    for (int unsigned i = 0; i < n_vals; i++) send_byte(8'($urandom));
  endtask

  // Stop offering and wait for every pending result
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: check each accepted result, then pick the next ready value
  initial begin
    int unsigned hold_left;
    tlvd_result_t got;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.msg_tag    = out_tdata[7:0];
        got.value_byte = out_tdata[15:8];
        got.msg_length = out_tdata[31:16];
        got.msg_last   = out_tlast;
        got.has_value  = out_tuser;
        board.check_result(got);
      end
      if (stall_req) begin
        stall_req = 1'b0;
        hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !sink_idle_on || ($urandom_range(99) >= 32);
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WDOG_LIMIT) begin
        $display("tlv_frame_deframer verification failed");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    logic [7:0] directed_bytes[] = '{
      8'h00, 8'h00,                             // empty message
      8'hFF, 8'h01, 8'hFF,                      // one value byte, all-ones tag and value
      8'h5A, 8'hFF, 8'h00, 8'h00,               // escaped length of zero
      8'hA5, 8'hFF, 8'h00, 8'h02, 8'h00, 8'h80, // short escaped length
      8'h80, 8'h02, 8'h7F, 8'h01,               // plain two-byte message
      8'h3C, 8'hFE                              // longest short length, values follow below
    };
    int unsigned r, len, stop_at;
    bit ext;

    board        = new();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    stall_req    = 1'b0;
    n_sent       = 0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = 8'h00;
    out_tready   = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corner cases
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    for (int i = 0; i < 254; i++) send_byte(8'($urandom));
    drain();

    // Receiver holds off while the sender keeps offering; input must back up
    stall_req   = 1'b1;
    src_idle_on = 1'b0;
    send_msg(8'h42, 16'd40, 1'b0, 40);
    drain();

    // Long escaped message, no idling on either side
    sink_idle_on = 1'b0;
    send_msg(8'hC3, 16'd255, 1'b1, 255);
    drain();

    // Random messages, mostly well formed, with idling on both sides
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    stop_at = n_sent + RANDOM_BYTES;
    while (n_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 10) begin
        // noise bytes
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (r < 18) begin
        // truncated message; later bytes are taken as its values
        len = $urandom_range(2, 12);
        send_msg(8'($urandom), 16'(len), 1'($urandom_range(1)), $urandom_range(0, len - 1));
      end else begin
        ext = ($urandom_range(99) < 25);
        r   = $urandom_range(99);
        if (r < 12) len = 0;
        else if (r < 80) len = $urandom_range(1, 12);
        else if (r < 95) len = $urandom_range(13, 60);
        else len = ext ? $urandom_range(200, 300) : $urandom_range(200, 254);
        send_msg(8'($urandom), 16'(len), ext, len);
      end
      if ($urandom_range(99) < 3) drain();
    end

    // Finish any open message, then start the largest length and stop partway
    while (board.phase != PH_TAG) send_byte(8'($urandom));
    send_msg(8'h0F, 16'hFFFF, 1'b1, 32);

    // Wind down
    drain();
    repeat (10) @(posedge clk);
    if (board.n_errors == 0 && board.pending_results.size() == 0) begin
      $display("tlv_frame_deframer verification clean");
    end else begin
      $display("tlv_frame_deframer verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/tlvd_pkg.sv
src/tlvd_parser.sv
src/tlvd_out_buf.sv
src/tlv_frame_deframer.sv
src/tlvd_checker.sv
bench/tb_tlv_frame_deframer.sv
